/* src/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the ramp/soak profile sequencer
// Operation codes, config register map, and the word and state-view structs.
// ----------------------------------------------------------------------------
package rss_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_SET   = 3'd1,
		OP_RAISE = 3'd2,
		OP_LOWER = 3'd3,
		OP_PLAY  = 3'd4,
		OP_LOAD  = 3'd5
	} op_t;

	// config register indexes (byte address = 4 * index)
	localparam logic [1:0] CFG_SIM_ENABLE = 2'd0;
	localparam logic [1:0] CFG_BAND       = 2'd1;
	localparam logic [1:0] CFG_SIM_GAIN   = 2'd2;
	localparam logic [1:0] CFG_NUDGE_STEP = 2'd3;

	localparam logic       SIM_ENABLE_RST = 1'b0;
	localparam logic [9:0] BAND_RST       = 10'd50;
	localparam logic [8:0] SIM_GAIN_RST   = 9'd26;
	localparam logic [9:0] NUDGE_STEP_RST = 10'd100;

	typedef struct packed {
		logic       sim_enable;
		logic [9:0] band;
		logic [8:0] sim_gain;
		logic [9:0] nudge_step;
	} rss_cfg_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] temperature;
		logic signed [15:0] value;
		logic [1:0]         profile_id;
		logic [3:0]         seg_index;
		logic [15:0]        seg_duration;
		logic               seg_last;
	} rss_item_t;

	// state after one word, as shown on the result side
	typedef struct packed {
		logic signed [15:0] temp;
		logic signed [15:0] setpoint;
		logic               auto_mode;
		logic [3:0]         segment;
		logic               hold_running;
		logic [15:0]        hold_elapsed;
		logic               status;
		logic               done;
	} rss_view_t;

endpackage

/* src/rss_cfg.sv */
// ----------------------------------------------------------------------------
// rss_cfg: APB-style configuration registers
// Holds sim_enable, band, sim_gain and nudge_step; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module rss_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output rss_pkg::rss_cfg_t  cfg
);
	import rss_pkg::*;

	rss_cfg_t   cfg_q;
	logic       wr;
	logic [1:0] idx;

	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sim_enable <= SIM_ENABLE_RST;
			cfg_q.band       <= BAND_RST;
			cfg_q.sim_gain   <= SIM_GAIN_RST;
			cfg_q.nudge_step <= NUDGE_STEP_RST;
		end else if (wr) begin
			case (idx)
				CFG_SIM_ENABLE: cfg_q.sim_enable <= pwdata[0];
				CFG_BAND:       cfg_q.band       <= pwdata[9:0];
				CFG_SIM_GAIN:   cfg_q.sim_gain   <= pwdata[8:0];
				CFG_NUDGE_STEP: cfg_q.nudge_step <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			CFG_SIM_ENABLE: prdata = {31'b0, cfg_q.sim_enable};
			CFG_BAND:       prdata = {22'b0, cfg_q.band};
			CFG_SIM_GAIN:   prdata = {23'b0, cfg_q.sim_gain};
			CFG_NUDGE_STEP: prdata = {22'b0, cfg_q.nudge_step};
			default:        prdata = '0;
		endcase
	end

endmodule

/* src/rss_seg_store.sv */
// ----------------------------------------------------------------------------
// rss_seg_store: segment setpoint and hold-time tables
// One write port; setpoint has a play read and a next-segment read, duration
// has a current-segment read. Reads are registered with write bypass.
// ----------------------------------------------------------------------------
module rss_seg_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_sp,
	input  logic [15:0]   wr_dur,
	input  logic          play_rd,
	input  logic [AW-1:0] play_addr,
	input  logic [AW-1:0] nxt_addr,
	input  logic [AW-1:0] cur_addr,
	output logic [15:0]   play_sp,
	output logic [15:0]   nxt_sp,
	output logic [15:0]   cur_dur
);

	logic [15:0] sp_mem  [DEPTH];
	logic [15:0] dur_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sp_mem[wr_addr]  <= wr_sp;
			dur_mem[wr_addr] <= wr_dur;
		end
		if (play_rd) begin
			play_sp <= (wr_en && wr_addr == play_addr) ? wr_sp : sp_mem[play_addr];
		end
		nxt_sp  <= (wr_en && wr_addr == nxt_addr) ? wr_sp : sp_mem[nxt_addr];
		cur_dur <= (wr_en && wr_addr == cur_addr) ? wr_dur : dur_mem[cur_addr];
	end

endmodule

/* src/rss_ctrl.sv */
// ----------------------------------------------------------------------------
// rss_ctrl: sequencer state and per-word update
// Manual setpoint ops, play, segment load, and the tick path with the
// lag model, hold timer and segment advance.
// ----------------------------------------------------------------------------
module rss_ctrl #(
	parameter int PROFILES = 4,
	parameter int SEGMENTS = 16,
	parameter int AW       = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rss_pkg::rss_cfg_t   cfg,
	input  logic                adv,
	input  rss_pkg::rss_item_t  item,
	input  logic [1:0]          in_profile_id,
	input  logic [15:0]         play_sp,
	input  logic [15:0]         nxt_sp,
	input  logic [15:0]         cur_dur,
	output rss_pkg::rss_view_t  view,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [15:0]         wr_sp,
	output logic [15:0]         wr_dur,
	output logic [AW-1:0]       play_addr,
	output logic [AW-1:0]       cur_addr,
	output logic [AW-1:0]       nxt_addr
);
	import rss_pkg::*;

	localparam int PW = (PROFILES > 1) ? $clog2(PROFILES) : 1;

	logic               mode_q, mode_n;
	logic [1:0]         prof_q, prof_n;
	logic [3:0]         seg_q, seg_n;
	logic signed [15:0] sp_q, sp_n;
	logic               run_q, run_n;
	logic [15:0]        el_q, el_n;
	logic signed [15:0] temp_q, temp_n;
	logic signed [23:0] sim_q, sim_n;
	logic [4:0]         len_q [PROFILES];

	logic               status_n, done_n;
	logic               len_we;
	logic [4:0]         cur_len, play_len;
	logic               prof_ok, load_ok;
	logic [15:0]        el_inc;
	logic signed [24:0] lag_diff;
	logic signed [34:0] lag_prod;
	logic signed [27:0] lag_sum;
	logic signed [16:0] err;
	logic [16:0]        err_abs;
	logic signed [16:0] nudge_sum;

	function automatic logic [AW-1:0] slot(input logic [1:0] p, input logic [4:0] s);
		logic [AW-1:0] a;
		a = '0;
		if (32'(p) < PROFILES && 32'(s) < SEGMENTS) begin
			a = AW'(32'(p) * 32'(SEGMENTS) + 32'(s));
		end
		return a;
	endfunction

	assign prof_ok  = 32'(item.profile_id) < PROFILES;
	assign load_ok  = prof_ok && 32'(item.seg_index) < SEGMENTS;
	assign cur_len  = (32'(prof_q) < PROFILES) ? len_q[PW'(prof_q)] : 5'd0;
	assign play_len = prof_ok ? len_q[PW'(item.profile_id)] : 5'd0;
	assign el_inc   = (el_q == 16'hFFFF) ? el_q : el_q + 16'd1;

	// lag model: sim += floor((sp*256 - sim) * gain / 256)
	assign lag_diff = $signed({sp_q[15], sp_q, 8'h00}) - 25'(sim_q);
	assign lag_prod = lag_diff * $signed({1'b0, cfg.sim_gain});
	assign lag_sum  = 28'(sim_q) + 28'($signed(lag_prod[34:8]));

	always_comb begin
		mode_n    = mode_q;
		prof_n    = prof_q;
		seg_n     = seg_q;
		sp_n      = sp_q;
		run_n     = run_q;
		el_n      = el_q;
		temp_n    = temp_q;
		sim_n     = sim_q;
		status_n  = 1'b0;
		done_n    = 1'b0;
		wr_en     = 1'b0;
		len_we    = 1'b0;
		err       = '0;
		err_abs   = '0;
		nudge_sum = '0;
		if (adv) begin
			case (item.op)
				OP_TICK: begin
					if (cfg.sim_enable) begin
						temp_n = sim_q[23:8];
						if (lag_sum > 28'sd8388607) begin
							sim_n = 24'sh7FFFFF;
						end else if (lag_sum < -28'sd8388608) begin
							sim_n = 24'sh800000;
						end else begin
							sim_n = lag_sum[23:0];
						end
					end else begin
						temp_n = item.temperature;
					end
					err     = 17'(sp_q) - 17'(temp_n);
					err_abs = err[16] ? -err : err;
					if (mode_q) begin
						if (run_q) begin
							el_n = el_inc;
							if (el_inc >= cur_dur) begin
								if ({1'b0, seg_q} + 5'd1 >= cur_len) begin
									mode_n = 1'b0;
									sp_n   = '0;
									done_n = 1'b1;
								end else begin
									seg_n = seg_q + 4'd1;
									sp_n  = nxt_sp;
								end
								run_n = 1'b0;
								el_n  = '0;
							end
						end else if (err_abs < {7'b0, cfg.band}) begin
							run_n = 1'b1;
							el_n  = '0;
						end
					end
				end
				OP_SET: begin
					sp_n = item.value;
				end
				OP_RAISE, OP_LOWER: begin
					if (item.op == OP_RAISE) begin
						nudge_sum = 17'(sp_q) + $signed({7'b0, cfg.nudge_step});
					end else begin
						nudge_sum = 17'(sp_q) - $signed({7'b0, cfg.nudge_step});
					end
					if (nudge_sum > 17'sd32767) begin
						sp_n = 16'sh7FFF;
					end else if (nudge_sum < -17'sd32768) begin
						sp_n = 16'sh8000;
					end else begin
						sp_n = nudge_sum[15:0];
					end
				end
				OP_PLAY: begin
					if (!prof_ok || play_len == 5'd0) begin
						status_n = 1'b1;
					end else begin
						prof_n = item.profile_id;
						seg_n  = '0;
						run_n  = 1'b0;
						el_n   = '0;
						mode_n = 1'b1;
						sp_n   = play_sp;
					end
				end
				OP_LOAD: begin
					wr_en  = load_ok;
					len_we = load_ok && item.seg_last;
				end
				default: ;
			endcase
		end
	end

	assign wr_addr   = slot(item.profile_id, {1'b0, item.seg_index});
	assign wr_sp     = item.value;
	assign wr_dur    = item.seg_duration;
	assign play_addr = slot(in_profile_id, 5'd0);
	assign cur_addr  = slot(prof_n, {1'b0, seg_n});
	assign nxt_addr  = slot(prof_n, {1'b0, seg_n} + 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			prof_q <= '0;
			seg_q  <= '0;
			sp_q   <= '0;
			run_q  <= 1'b0;
			el_q   <= '0;
			temp_q <= '0;
			sim_q  <= '0;
			for (int i = 0; i < PROFILES; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			mode_q <= mode_n;
			prof_q <= prof_n;
			seg_q  <= seg_n;
			sp_q   <= sp_n;
			run_q  <= run_n;
			el_q   <= el_n;
			temp_q <= temp_n;
			sim_q  <= sim_n;
			if (len_we) begin
				len_q[PW'(item.profile_id)] <= {1'b0, item.seg_index} + 5'd1;
			end
		end
	end

	assign view.temp         = temp_n;
	assign view.setpoint     = sp_n;
	assign view.auto_mode    = mode_n;
	assign view.segment      = seg_n;
	assign view.hold_running = run_n;
	assign view.hold_elapsed = el_n;
	assign view.status       = status_n;
	assign view.done         = done_n;

endmodule

/* src/ramp_soak_profile_sequencer.sv */
// ----------------------------------------------------------------------------
// ramp_soak_profile_sequencer: ramp/soak temperature profile sequencer
// Words pass the input stage, then the state stage; one word per cycle while
// out_stall is low, as the state update is a single registered pass.
// Reset clears mode, setpoint, timer, temperatures and profile lengths and loads
// the register defaults; segment tables are not cleared and hold no value
// until loaded.
// ----------------------------------------------------------------------------
module ramp_soak_profile_sequencer #(
	parameter int PROFILES = 4,
	parameter int SEGMENTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [15:0] temperature,
	input  logic signed [15:0] value,
	input  logic [1:0]         profile_id,
	input  logic [3:0]         seg_index,
	input  logic [15:0]        seg_duration,
	input  logic               seg_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temp_now,
	output logic signed [15:0] setpoint_now,
	output logic               auto_mode,
	output logic [3:0]         segment_now,
	output logic [15:0]        time_left,
	output logic               status,
	output logic               profile_done,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import rss_pkg::*;

	localparam int SLOTS = PROFILES * SEGMENTS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	rss_cfg_t      cfg;
	rss_item_t     item_s1;
	logic          valid_s1;
	rss_view_t     view_s2;
	logic          valid_s2;
	rss_view_t     view_n;
	logic          accept;
	logic          adv;
	logic          wr_en;
	logic [AW-1:0] wr_addr, play_addr, cur_addr, nxt_addr;
	logic [15:0]   wr_sp, wr_dur;
	logic [15:0]   play_sp, nxt_sp, cur_dur;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op           <= op_t'(op);
			item_s1.temperature  <= temperature;
			item_s1.value        <= value;
			item_s1.profile_id   <= profile_id;
			item_s1.seg_index    <= seg_index;
			item_s1.seg_duration <= seg_duration;
			item_s1.seg_last     <= seg_last;
		end
		if (adv) begin
			view_s2 <= view_n;
		end
	end

	rss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rss_ctrl #(
		.PROFILES (PROFILES),
		.SEGMENTS (SEGMENTS),
		.AW       (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.adv           (adv),
		.item          (item_s1),
		.in_profile_id (profile_id),
		.play_sp       (play_sp),
		.nxt_sp        (nxt_sp),
		.cur_dur       (cur_dur),
		.view          (view_n),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_sp         (wr_sp),
		.wr_dur        (wr_dur),
		.play_addr     (play_addr),
		.cur_addr      (cur_addr),
		.nxt_addr      (nxt_addr)
	);

	rss_seg_store #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_sp     (wr_sp),
		.wr_dur    (wr_dur),
		.play_rd   (accept),
		.play_addr (play_addr),
		.nxt_addr  (nxt_addr),
		.cur_addr  (cur_addr),
		.play_sp   (play_sp),
		.nxt_sp    (nxt_sp),
		.cur_dur   (cur_dur)
	);

	// cur_dur only moves when the state stage advances, so it stays aligned
	// with the word held in the result register
	always_comb begin
		if (view_s2.hold_running) begin
			time_left = (view_s2.hold_elapsed >= cur_dur) ? 16'd0
				: cur_dur - view_s2.hold_elapsed;
		end else begin
			time_left = cur_dur;
		end
	end

	assign out_valid    = valid_s2;
	assign temp_now     = view_s2.temp;
	assign setpoint_now = view_s2.setpoint;
	assign auto_mode    = view_s2.auto_mode;
	assign segment_now  = view_s2.segment;
	assign status       = view_s2.status;
	assign profile_done = view_s2.done;

endmodule

/* verif/ramp_soak_profile_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// ramp_soak_profile_sequencer_tb: self-checking bench for the profile sequencer
// Drives directed and random words through the valid/stall input, programs the
// four config registers over APB between phases, and checks every result word
// field by field against an in-bench model of tables, timer and lag model.
// ----------------------------------------------------------------------------
module ramp_soak_profile_sequencer_tb;
	import rss_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 85;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam longint LAG_MAX = 64'sd8388607;
	localparam longint LAG_MIN = -64'sd8388608;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] temperature;
		logic signed [15:0] value;
		logic [1:0]         profile_id;
		logic [3:0]         seg_index;
		logic [15:0]        seg_duration;
		logic               seg_last;
	} word_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic signed [15:0] setpoint;
		logic               auto_mode;
		logic [3:0]         segment;
		logic [15:0]        time_left;
		logic               status;
		logic               done;
	} reading_t;

	class profile_scoreboard;
		bit          sim_on = SIM_ENABLE_RST;
		bit [9:0]    band   = BAND_RST;
		bit [8:0]    gain   = SIM_GAIN_RST;
		bit [9:0]    nudge  = NUDGE_STEP_RST;
		logic [15:0] seg_sp [64];
		logic [15:0] seg_hold [64];
		int          plen [4];
		bit          auto_on;
		bit [1:0]    prof;
		bit [3:0]    seg;
		bit          timing;
		int          elapsed;
		int          setpoint;
		int          temp;
		longint      lag;
		reading_t    due [$];
		int          failures, checked, completions, refusals;

		function int clamp16(int x);
			if (x > 32767) return 32767;
			if (x < -32768) return -32768;
			return x;
		endfunction

		function int awaited();
			return due.size();
		endfunction

		function void take_setting(logic [1:0] idx, logic [31:0] data);
			case (idx)
				CFG_SIM_ENABLE: sim_on = data[0];
				CFG_BAND:       band = data[9:0];
				CFG_SIM_GAIN:   gain = data[8:0];
				CFG_NUDGE_STEP: nudge = data[9:0];
				default: ;
			endcase
		endfunction

		function void note_word(word_t w);
			reading_t r;
			longint   diff, nxt;
			int       err, hold, remain;
			r = '0;
			case (w.op)
				OP_TICK: begin
					if (sim_on) begin
						temp = int'(lag >>> 8);
						diff = longint'(setpoint) * 256 - lag;
						nxt = lag + ((diff * longint'(gain)) >>> 8);
						if (nxt > LAG_MAX) nxt = LAG_MAX;
						if (nxt < LAG_MIN) nxt = LAG_MIN;
						lag = nxt;
					end else begin
						temp = int'(w.temperature);
					end
					if (auto_on && timing) begin
						if (elapsed < 65535) elapsed++;
						if (elapsed >= int'(seg_hold[{prof, seg}])) begin
							if (int'(seg) + 1 >= plen[prof]) begin
								auto_on = 1'b0;
								setpoint = 0;
								r.done = 1'b1;
								completions++;
							end else begin
								seg++;
								setpoint = int'($signed(seg_sp[{prof, seg}]));
							end
							timing = 1'b0;
							elapsed = 0;
						end
					end else if (auto_on) begin
						err = setpoint - temp;
						if (err < 0) err = -err;
						if (err < int'(band)) begin
							timing = 1'b1;
							elapsed = 0;
						end
					end
				end
				OP_SET:   setpoint = int'(w.value);
				OP_RAISE: setpoint = clamp16(setpoint + int'(nudge));
				OP_LOWER: setpoint = clamp16(setpoint - int'(nudge));
				OP_PLAY: begin
					if (plen[w.profile_id] == 0) begin
						r.status = 1'b1;
						refusals++;
					end else begin
						prof = w.profile_id;
						seg = '0;
						timing = 1'b0;
						elapsed = 0;
						auto_on = 1'b1;
						setpoint = int'($signed(seg_sp[{w.profile_id, 4'd0}]));
					end
				end
				OP_LOAD: begin
					seg_sp[{w.profile_id, w.seg_index}] = w.value;
					seg_hold[{w.profile_id, w.seg_index}] = w.seg_duration;
					if (w.seg_last) plen[w.profile_id] = int'(w.seg_index) + 1;
				end
				default: ;
			endcase
			hold = int'(seg_hold[{prof, seg}]);
			if (timing) remain = (elapsed >= hold) ? 0 : hold - elapsed;
			else remain = hold;
			r.temp = 16'(temp);
			r.setpoint = 16'(setpoint);
			r.auto_mode = auto_on;
			r.segment = seg;
			r.time_left = 16'(remain);
			due.push_back(r);
		endfunction

		function void match_field(string field, logic signed [31:0] want, logic signed [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_readout(reading_t got);
			reading_t want;
			if (due.size() == 0) begin
				$error("result word with nothing awaited");
				failures++;
				return;
			end
			want = due.pop_front();
			checked++;
			match_field("temp_now", want.temp, got.temp);
			match_field("setpoint_now", want.setpoint, got.setpoint);
			match_field("auto_mode", want.auto_mode, got.auto_mode);
			match_field("segment_now", want.segment, got.segment);
			match_field("time_left", want.time_left, got.time_left);
			match_field("status", want.status, got.status);
			match_field("profile_done", want.done, got.done);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         op;
	logic signed [15:0] temperature;
	logic signed [15:0] value;
	logic [1:0]         profile_id;
	logic [3:0]         seg_index;
	logic [15:0]        seg_duration;
	logic               seg_last;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] temp_now;
	logic signed [15:0] setpoint_now;
	logic               auto_mode;
	logic [3:0]         segment_now;
	logic [15:0]        time_left;
	logic               status;
	logic               profile_done;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	ramp_soak_profile_sequencer dut (.*);

	profile_scoreboard sb;
	bit                quiet;
	bit [15:0]         loaded [4];
	int                words_sent, settings;
	int                phase_end;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 12);
	endfunction

	// a final mark is legal only once every lower segment holds data
	function automatic bit can_close(logic [1:0] p, logic [3:0] s);
		bit [16:0] need;
		need = (17'd1 << (int'(s) + 1)) - 17'd1;
		return ((loaded[p] | (16'd1 << s)) & need) == need;
	endfunction

	function automatic word_t make_word(logic [2:0] code);
		word_t w;
		w.op = code;
		w.temperature = 16'($urandom);
		w.value = 16'($urandom);
		w.profile_id = 2'($urandom);
		w.seg_index = 4'($urandom);
		w.seg_duration = 16'($urandom);
		w.seg_last = 1'($urandom);
		if (code == OP_LOAD && w.seg_last && !can_close(w.profile_id, w.seg_index))
			w.seg_last = 1'b0;
		return w;
	endfunction

	task automatic send_word(input word_t w);
		int gap;
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= w.op;
		temperature <= w.temperature;
		value <= w.value;
		profile_id <= w.profile_id;
		seg_index <= w.seg_index;
		seg_duration <= w.seg_duration;
		seg_last <= w.seg_last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
		if (w.op == OP_LOAD) loaded[w.profile_id][w.seg_index] = 1'b1;
		if (w.op != OP_SPARE_6 && w.op != OP_SPARE_7) words_sent++;
	endtask

	task automatic send_load(input logic [1:0] p, input logic [3:0] s,
			input logic signed [15:0] v, input logic [15:0] hold, input logic last);
		word_t w;
		w = make_word(OP_LOAD);
		w.profile_id = p;
		w.seg_index = s;
		w.value = v;
		w.seg_duration = hold;
		w.seg_last = last;
		send_word(w);
	endtask

	task automatic send_op(input logic [2:0] code, input logic [1:0] p,
			input logic signed [15:0] t, input logic signed [15:0] v);
		word_t w;
		w = make_word(code);
		w.profile_id = p;
		w.temperature = t;
		w.value = v;
		send_word(w);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.take_setting(idx, data);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input int ph);
		logic [31:0] sim, bnd, gn, stp;
		sim = $urandom_range(0, 1);
		bnd = $urandom_range(0, 1000);
		gn = $urandom_range(0, 256);
		stp = $urandom_range(0, 1000);
		case (ph)
			0: {sim, bnd, gn, stp} = {32'd0, 32'd1000, 32'd0, 32'd1000};
			1: {sim, bnd, gn, stp} = {32'd1, 32'd1000, 32'd256, 32'd0};
			2: {sim, bnd, gn, stp} = {32'd1, 32'd0, 32'd0, 32'd1};
			3: {sim, bnd, gn, stp} = {32'd0, 32'd1, 32'd256, 32'd1000};
			default: ;
		endcase
		apb_write(CFG_SIM_ENABLE, sim);
		apb_write(CFG_BAND, bnd);
		apb_write(CFG_SIM_GAIN, gn);
		apb_write(CFG_NUDGE_STEP, stp);
		settings++;
	endtask

	// load a profile, play it, then tick mostly near the setpoint until it ends, 80 words pass or the phase is full
	task automatic run_profile();
		logic [1:0] p;
		int         n, ticks, off;
		logic [15:0] sp, hold;
		p = 2'($urandom);
		n = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 5);
		quiet = ($urandom_range(0, 4) == 0);
		for (int s = 0; s < n; s++) begin
			sp = ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 8000) - 4000);
			hold = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
			send_load(p, 4'(s), sp, hold, s == n - 1);
		end
		send_op(OP_PLAY, p, 16'($urandom), 16'($urandom));
		ticks = 0;
		while (sb.auto_on && ticks < 80 && words_sent < phase_end) begin
			if ($urandom_range(0, 11) == 0) begin
				send_word(make_word(3'($urandom_range(0, 7))));
			end else begin
				off = (sb.band == 0) ? $urandom_range(0, 200) : $urandom_range(0, sb.band - 1);
				if ($urandom_range(0, 6) == 0) off = $urandom_range(0, 65535);
				if ($urandom_range(0, 1)) off = -off;
				send_op(OP_TICK, 2'($urandom), 16'(sb.clamp16(sb.setpoint + off)),
					16'($urandom));
			end
			ticks++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_readout(reading_t'{temp_now, setpoint_now, auto_mode, segment_now,
				time_left, status, profile_done});
	end

	initial begin
		int gap;
		out_stall <= 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#(LIMIT_CYCLES * 4);
		$display("ramp_soak_profile_sequencer verification failed");
		$finish;
	end

	initial begin
		sb = new();
		phase_end = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_TICK;
		temperature <= '0;
		value <= '0;
		profile_id <= '0;
		seg_index <= '0;
		seg_duration <= '0;
		seg_last <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// segment 0 of profile 0 first: time_left reads it from the start
		send_load(0, 0, 16'sd1000, 16'd2, 1'b0);
		send_load(0, 1, -16'sd32768, 16'd0, 1'b0);
		send_load(0, 2, 16'sd32767, 16'hFFFF, 1'b1);
		send_load(1, 0, 16'sd500, 16'd1, 1'b1);
		send_load(2, 15, 16'sd0, 16'hFFFF, 1'b0);
		send_op(OP_PLAY, 3, 0, 0);
		send_op(OP_SET, 0, 0, 16'sd32767);
		send_op(OP_RAISE, 0, 0, 0);
		send_op(OP_SET, 0, 0, -16'sd32768);
		send_op(OP_LOWER, 0, 0, 0);
		send_op(OP_SPARE_6, 0, 0, 0);
		send_op(OP_SPARE_7, 0, 0, 0);
		send_op(OP_PLAY, 1, 0, 0);
		send_op(OP_TICK, 0, 16'sd500, 0);
		send_op(OP_TICK, 0, 16'sd32767, 0);
		send_op(OP_PLAY, 0, 0, 0);
		send_op(OP_SET, 0, 0, 16'sd990);
		send_op(OP_TICK, 0, 16'sd1000, 0);
		send_op(OP_TICK, 0, -16'sd32768, 0);
		send_op(OP_TICK, 0, 16'sd0, 0);
		send_op(OP_TICK, 0, -16'sd32768, 0);
		send_op(OP_TICK, 0, 16'sd0, 0);
		send_op(OP_TICK, 0, 16'sd32767, 0);
		send_op(OP_PLAY, 0, 0, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			configure(ph);
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 3) != 0) run_profile();
				else repeat (4) send_word(make_word(3'($urandom_range(0, 7))));
			end
		end

		in_valid <= 1'b0;
		while (sb.awaited() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words driven, %0d results checked over %0d register settings",
			words_sent, sb.checked, settings);
		$display("%0d profiles ran to their last segment, %0d plays of empty profiles refused",
			sb.completions, sb.refusals);
		if (sb.failures == 0) begin
			$display("ramp_soak_profile_sequencer verification clean");
		end else begin
			$display("ramp_soak_profile_sequencer verification failed");
		end
		$finish;
	end

endmodule
